[hw/rtl/apu_pkg.sv]
// Shared types, constants and the square root step for the parameter update block.
package apu_pkg;

    localparam int ADDR_W      = 18;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] CFG_FIRST_DECAY  = 2'd0;
    localparam logic [1:0] CFG_SECOND_DECAY = 2'd1;
    localparam logic [1:0] CFG_STEP_SIZE    = 2'd2;

    localparam logic [15:0] FIRST_DECAY_RST  = 16'd58982;
    localparam logic [15:0] SECOND_DECAY_RST = 16'd65470;
    localparam logic [15:0] STEP_SIZE_RST    = 16'd16384;

    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
    localparam logic [31:0] EPS_Q16 = 32'd6554;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic signed [31:0] grad;
        logic signed [31:0] pos;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [31:0]        p1;
        logic [31:0]        p2;
    } apu_item_t;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] res;
    } sqrt_st_t;

    // one digit of the bit-pair square root
    function automatic sqrt_st_t sqrt_step(input sqrt_st_t s, input logic [63:0] b);
        sqrt_st_t    r;
        logic [63:0] t;
        t = s.res + b;
        if (s.x >= t)
        begin
            r.x   = s.x - t;
            r.res = (s.res >> 1) + b;
        end
        else
        begin
            r.x   = s.x;
            r.res = s.res >> 1;
        end
        return r;
    endfunction

endpackage

[hw/rtl/apu_front.sv]
// Front end: accepts words, reduces indexes, advances decay powers, feeds the queue.
module apu_front #(
    parameter int MAX_POINTS = 128,
    parameter int MAX_DIM    = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [6:0]         point_index,
    input  logic [4:0]         dim_index,
    input  logic               new_step,
    input  logic signed [31:0] grad_value,
    input  logic signed [31:0] position,
    input  logic signed [31:0] lower_bound,
    input  logic signed [31:0] upper_bound,
    input  logic [15:0]        first_decay,
    input  logic [15:0]        second_decay,
    input  logic               q_full,
    input  logic               clearing,
    output logic               push,
    output apu_pkg::apu_item_t push_item
);
    import apu_pkg::*;

    localparam logic [ADDR_W-1:0] MP = ADDR_W'(MAX_POINTS);
    localparam logic [ADDR_W-1:0] MD = ADDR_W'(MAX_DIM);

    logic [31:0]       p1_reg, p1_next;
    logic [31:0]       p2_reg, p2_next;
    logic [47:0]       p1_prod, p2_prod;
    logic [ADDR_W-1:0] pr, dr;

    assign in_stall = q_full | clearing;
    assign push     = in_valid & ~in_stall;

    // index modulo by restoring subtraction, narrow values only
    always_comb
    begin
        pr = ADDR_W'(point_index);
        for (int k = 6; k >= 0; k--)
        begin
            if (pr >= (MP << k))
                pr = pr - (MP << k);
        end
        dr = ADDR_W'(dim_index);
        for (int k = 4; k >= 0; k--)
        begin
            if (dr >= (MD << k))
                dr = dr - (MD << k);
        end
    end

    assign p1_prod = p1_reg * first_decay;
    assign p2_prod = p2_reg * second_decay;
    assign p1_next = new_step ? p1_prod[47:16] : p1_reg;
    assign p2_next = new_step ? p2_prod[47:16] : p2_reg;

    always_comb
    begin
        push_item.addr = pr * MD + dr;
        push_item.grad = grad_value;
        push_item.pos  = position;
        push_item.lo   = lower_bound;
        push_item.hi   = upper_bound;
        push_item.p1   = p1_next;
        push_item.p2   = p2_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= ONE_Q31;
            p2_reg <= ONE_Q31;
        end
        else if (push)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
    end

endmodule

[hw/rtl/apu_queue.sv]
// Short queue of classified words between front and back.
module apu_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  apu_pkg::apu_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output apu_pkg::apu_item_t head
);
    import apu_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    apu_item_t       store [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg;

    assign full  = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = store[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            store[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[hw/rtl/apu_back.sv]
// Back end: moment memories, moment update, square roots, divisions, clamp, output register.
module apu_back #(
    parameter int DEPTH = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  apu_pkg::apu_item_t q_head,
    output logic               q_pop,
    input  logic [15:0]        first_decay,
    input  logic [15:0]        second_decay,
    input  logic [15:0]        step_size,
    output logic               clearing,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] updated_position
);
    import apu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [15:0] {
        ST_CLEAR     = 16'b0000_0000_0000_0001,
        ST_IDLE      = 16'b0000_0000_0000_0010,
        ST_MUL_A     = 16'b0000_0000_0000_0100,
        ST_MUL_B     = 16'b0000_0000_0000_1000,
        ST_MUL_C     = 16'b0000_0000_0001_0000,
        ST_MUL_D     = 16'b0000_0000_0010_0000,
        ST_MUL_E     = 16'b0000_0000_0100_0000,
        ST_MUL_F     = 16'b0000_0000_1000_0000,
        ST_SQRT      = 16'b0000_0001_0000_0000,
        ST_CORR_MUL  = 16'b0000_0010_0000_0000,
        ST_DIV1      = 16'b0000_0100_0000_0000,
        ST_CORR_SAT  = 16'b0000_1000_0000_0000,
        ST_DELTA_MUL = 16'b0001_0000_0000_0000,
        ST_DIV2      = 16'b0010_0000_0000_0000,
        ST_CLAMP     = 16'b0100_0000_0000_0000,
        ST_OUT       = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] mem_m [DEPTH];
    logic [31:0] mem_v [DEPTH];

    logic [AW-1:0] clr_cnt_reg;
    logic [5:0]    cnt_reg, cnt_next;
    logic          out_valid_reg;

    apu_item_t          cur_reg;
    logic [31:0]        m_rd_reg, v_rd_reg;
    logic signed [49:0] pa_reg, pb_reg;
    logic [47:0]        va_reg;
    logic [48:0]        vb_reg;
    logic signed [31:0] m_reg;
    logic [31:0]        gsq_reg;
    sqrt_st_t           s1_reg, s2_reg;
    logic [63:0]        bit_reg;
    logic [63:0]        num_reg;
    logic [31:0]        rem_reg, div_reg;
    logic [31:0]        corr_reg;
    logic signed [31:0] clamp_reg;
    logic signed [31:0] res_reg;

    logic               mem_we;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wd_m, wd_v;
    logic               load_out;

    logic signed [16:0] b1s;
    logic signed [17:0] nb1s;
    logic [16:0]        nb2;
    logic signed [50:0] msum;
    logic signed [50:0] mshift;
    logic [31:0]        gmag;
    logic [63:0]        gsq_full;
    logic [49:0]        vsum;
    logic [31:0]        vsat;
    logic [31:0]        q1, q2;
    logic [32:0]        div_r;
    logic               div_ge;
    logic [31:0]        mmag;
    logic signed [65:0] np, npc;

    assign clearing         = (state_reg == ST_CLEAR);
    assign out_valid        = out_valid_reg;
    assign updated_position = res_reg;

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    assign b1s  = signed'({1'b0, first_decay});
    assign nb1s = signed'({1'b0, 17'(17'h10000 - {1'b0, first_decay})});
    assign nb2  = 17'(17'h10000 - {1'b0, second_decay});

    assign msum   = 51'(pa_reg) + 51'(pb_reg);
    assign mshift = msum >>> 16;

    assign gmag     = cur_reg.grad[31] ? 32'(-cur_reg.grad) : cur_reg.grad;
    assign gsq_full = gmag * gmag;

    assign vsum = 50'(va_reg) + 50'(vb_reg);
    assign vsat = (|vsum[49:48]) ? 32'hFFFF_FFFF : vsum[47:16];

    assign q1 = ONE_Q31 - ((cur_reg.p1 > ONE_Q31) ? ONE_Q31 : cur_reg.p1);
    assign q2 = ONE_Q31 - ((cur_reg.p2 > ONE_Q31) ? ONE_Q31 : cur_reg.p2);

    // restoring divider, one quotient bit per cycle
    assign div_r  = {rem_reg, num_reg[63]};
    assign div_ge = (div_r >= {1'b0, div_reg});

    assign mmag = m_reg[31] ? 32'(-m_reg) : m_reg;

    always_comb
    begin
        if (m_reg[31])
            np = 66'(cur_reg.pos) + signed'({2'b0, num_reg});
        else
            np = 66'(cur_reg.pos) - signed'({2'b0, num_reg});
        npc = np;
        if (npc > 66'(cur_reg.hi))
            npc = 66'(cur_reg.hi);
        if (npc < 66'(cur_reg.lo))
            npc = 66'(cur_reg.lo);
    end

    always_comb
    begin
        mem_we  = 1'b0;
        wr_addr = cur_reg.addr[AW-1:0];
        wd_m    = m_reg;
        wd_v    = vsat;
        if (state_reg == ST_CLEAR)
        begin
            mem_we  = 1'b1;
            wr_addr = clr_cnt_reg;
            wd_m    = '0;
            wd_v    = '0;
        end
        else if (state_reg == ST_MUL_F)
            mem_we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_m[wr_addr] <= wd_m;
            mem_v[wr_addr] <= wd_v;
        end
        if (q_pop)
        begin
            m_rd_reg <= mem_m[q_head.addr[AW-1:0]];
            v_rd_reg <= mem_v[q_head.addr[AW-1:0]];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_cnt_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (!q_empty)
                    state_next = ST_MUL_A;
            ST_MUL_A:     state_next = ST_MUL_B;
            ST_MUL_B:     state_next = ST_MUL_C;
            ST_MUL_C:     state_next = ST_MUL_D;
            ST_MUL_D:     state_next = ST_MUL_E;
            ST_MUL_E:     state_next = ST_MUL_F;
            ST_MUL_F:
            begin
                state_next = ST_SQRT;
                cnt_next   = 6'd31;
            end
            ST_SQRT:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_CORR_MUL;
            end
            ST_CORR_MUL:
            begin
                state_next = ST_DIV1;
                cnt_next   = 6'd47;
            end
            ST_DIV1:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_CORR_SAT;
            end
            ST_CORR_SAT:  state_next = ST_DELTA_MUL;
            ST_DELTA_MUL:
            begin
                state_next = ST_DIV2;
                cnt_next   = 6'd63;
            end
            ST_DIV2:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_CLAMP;
            end
            ST_CLAMP:     state_next = ST_OUT;
            ST_OUT:
                if (load_out)
                    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (!q_empty)
                    cur_reg <= q_head;
            ST_MUL_A:
                pa_reg <= b1s * signed'(m_rd_reg);
            ST_MUL_B:
                pb_reg <= nb1s * cur_reg.grad;
            ST_MUL_C:
            begin
                m_reg   <= mshift[31:0];
                gsq_reg <= (|gsq_full[63:48]) ? 32'hFFFF_FFFF : gsq_full[47:16];
            end
            ST_MUL_D:
                va_reg <= second_decay * v_rd_reg;
            ST_MUL_E:
                vb_reg <= nb2 * gsq_reg;
            ST_MUL_F:
            begin
                s1_reg.x   <= {16'b0, vsat, 16'b0};
                s1_reg.res <= '0;
                s2_reg.x   <= {1'b0, q2, 31'b0};
                s2_reg.res <= '0;
                bit_reg    <= 64'h4000_0000_0000_0000;
            end
            ST_SQRT:
            begin
                s1_reg  <= sqrt_step(s1_reg, bit_reg);
                s2_reg  <= sqrt_step(s2_reg, bit_reg);
                bit_reg <= bit_reg >> 2;
            end
            ST_CORR_MUL:
            begin
                num_reg <= {48'(step_size * s2_reg.res[31:0]), 16'b0};
                rem_reg <= '0;
                div_reg <= q1;
            end
            ST_DIV1, ST_DIV2:
            begin
                rem_reg <= div_ge ? 32'(div_r - {1'b0, div_reg}) : div_r[31:0];
                num_reg <= {num_reg[62:0], div_ge};
            end
            ST_CORR_SAT:
            begin
                if (q1 == '0)
                    corr_reg <= '0;
                else if (|num_reg[47:32])
                    corr_reg <= 32'hFFFF_FFFF;
                else
                    corr_reg <= num_reg[31:0];
            end
            ST_DELTA_MUL:
            begin
                num_reg <= corr_reg * mmag;
                rem_reg <= '0;
                div_reg <= s1_reg.res[31:0] + EPS_Q16;
            end
            ST_CLAMP:
                clamp_reg <= npc[31:0];
            // output word only changes when the previous one has been taken
            ST_OUT:
                if (load_out)
                    res_reg <= clamp_reg;
            default:
            begin
            end
        endcase
    end

endmodule

[hw/rtl/adam_parameter_update_core.sv]
// Top level: configuration registers, front end, queue and back end of the parameter update.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------------
//  in       | in_valid / in_stall | point_index dim_index new_step grad_value
//           |                     | position lower_bound upper_bound
//  out      | out_valid/out_stall | updated_position
//  cfg      | cfg_we              | cfg_index cfg_data
//
// In the back end each word passes through the 32-step square root
// pair and the 48- and 64-step restoring divisions sharing one divider.
// After reset the moment memories are zeroed one entry a cycle, all MAX_POINTS*MAX_DIM
// entries, with in_stall high; config writes are taken throughout.
// The queue holds up to four words, so the front keeps accepting while the back works
// and a finished word waits in the output register.
module adam_parameter_update_core #(
    parameter int MAX_POINTS = 128,
    parameter int MAX_DIM    = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [6:0]         point_index,
    input  logic [4:0]         dim_index,
    input  logic               new_step,
    input  logic signed [31:0] grad_value,
    input  logic signed [31:0] position,
    input  logic signed [31:0] lower_bound,
    input  logic signed [31:0] upper_bound,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] updated_position,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import apu_pkg::*;

    localparam int DEPTH = MAX_POINTS * MAX_DIM;

    logic [15:0] first_decay_reg, second_decay_reg, step_size_reg;
    logic        q_full, q_empty, q_pop, push, clearing;
    apu_item_t   push_item, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_decay_reg  <= FIRST_DECAY_RST;
            second_decay_reg <= SECOND_DECAY_RST;
            step_size_reg    <= STEP_SIZE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST_DECAY:  first_decay_reg  <= cfg_data;
                CFG_SECOND_DECAY: second_decay_reg <= cfg_data;
                CFG_STEP_SIZE:    step_size_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    apu_front #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DIM    (MAX_DIM)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .point_index  (point_index),
        .dim_index    (dim_index),
        .new_step     (new_step),
        .grad_value   (grad_value),
        .position     (position),
        .lower_bound  (lower_bound),
        .upper_bound  (upper_bound),
        .first_decay  (first_decay_reg),
        .second_decay (second_decay_reg),
        .q_full       (q_full),
        .clearing     (clearing),
        .push         (push),
        .push_item    (push_item)
    );

    apu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    apu_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .first_decay      (first_decay_reg),
        .second_decay     (second_decay_reg),
        .step_size        (step_size_reg),
        .clearing         (clearing),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .updated_position (updated_position)
    );

endmodule

[bench/tb_adam_parameter_update_core.sv]
// Testbench for the Adam parameter update core: queued driver, monitor and predictor.
`timescale 1ns / 100ps

module tb_adam_parameter_update_core;
    import apu_pkg::*;

    localparam int NPTS = 128;
    localparam int NDIM = 32;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct {
        logic [6:0]         pt;
        logic [4:0]         dm;
        logic               ns;
        logic signed [31:0] grad;
        logic signed [31:0] pos;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } coord_word_t;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall, new_step, cfg_we;
    logic [6:0] point_index;
    logic [4:0] dim_index;
    logic signed [31:0] grad_value, position, lower_bound, upper_bound, updated_position;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    adam_parameter_update_core dut (.*);

    // predictor state
    logic [31:0] mom1 [NPTS*NDIM];
    logic [31:0] mom2 [NPTS*NDIM];
    logic [31:0] pow1, pow2;
    logic [15:0] beta1, beta2, lrate;

    coord_word_t  pending_words[$];
    logic [31:0]  expected_pos[$];
    int mismatches = 0;
    int checked = 0;
    int idle_cycles = 0;
    bit timed_out = 0;
    bit quiet = 0;
    bit hold_send = 0;
    int send_gap = 0, recv_gap = 0;

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint floor16(input longint x);
        if (x >= 0)
            return x >>> 16;
        return -((-x + 65535) >>> 16);
    endfunction

    function automatic logic [31:0] predict_position(input coord_word_t w);
        int unsigned idx;
        longint g, m, np, delta;
        logic [63:0] gmag, gsq, v, denom, q1, q2, corr, mmag, p1c, p2c;
        idx = (w.pt % NPTS) * NDIM + (w.dm % NDIM);
        g = longint'(w.grad);
        if (w.ns)
        begin
            pow1 = 32'((64'(pow1) * beta1) >> 16);
            pow2 = 32'((64'(pow2) * beta2) >> 16);
        end
        m = floor16(longint'(beta1) * longint'($signed(mom1[idx]))
                    + longint'(65536 - int'(beta1)) * g);
        mom1[idx] = 32'(m);
        gmag = (g < 0) ? 64'(-g) : 64'(g);
        gsq = (gmag * gmag) >> 16;
        if (gsq > 64'hFFFF_FFFF)
            gsq = 64'hFFFF_FFFF;
        v = (64'(beta2) * mom2[idx] + 64'(65536 - int'(beta2)) * gsq) >> 16;
        if (v > 64'hFFFF_FFFF)
            v = 64'hFFFF_FFFF;
        mom2[idx] = 32'(v);
        denom = isqrt(v << 16) + 6554;
        p1c = (pow1 > ONE_Q31) ? 64'(ONE_Q31) : 64'(pow1);
        p2c = (pow2 > ONE_Q31) ? 64'(ONE_Q31) : 64'(pow2);
        q1 = 64'(ONE_Q31) - p1c;
        q2 = 64'(ONE_Q31) - p2c;
        if (q1 == 0)
            corr = 0;
        else
        begin
            corr = (64'(lrate) * isqrt(q2 << 31)) / q1;
            if (corr > 64'hFFFF_FFFF)
                corr = 64'hFFFF_FFFF;
        end
        mmag = (m < 0) ? 64'(-m) : 64'(m);
        delta = longint'((corr * mmag) / denom);
        if (m < 0)
            delta = -delta;
        np = longint'(w.pos) - delta;
        if (np > longint'(w.hi))
            np = longint'(w.hi);
        if (np < longint'(w.lo))
            np = longint'(w.lo);
        return 32'(np);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            point_index <= '0; dim_index <= '0; new_step <= 1'b0;
            grad_value <= '0; position <= '0; lower_bound <= '0; upper_bound <= '0;
            send_gap <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
                expected_pos.insert(expected_pos.size(),
                    predict_position('{point_index, dim_index, new_step,
                    grad_value, position, lower_bound, upper_bound}));
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() > 0 && !hold_send)
            begin
                coord_word_t w;
                w = pending_words.pop_front();
                in_valid <= 1'b1;
                point_index <= w.pt; dim_index <= w.dm; new_step <= w.ns;
                grad_value <= w.grad; position <= w.pos;
                lower_bound <= w.lo; upper_bound <= w.hi;
                if (!quiet && $urandom_range(0, 9) == 0)
                    send_gap <= $urandom_range(1, 15);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                checked++;
                if (expected_pos.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: got %h", updated_position);
                end
                else
                begin
                    logic [31:0] e;
                    e = expected_pos.pop_front();
                    if (e !== updated_position)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch %0d: expected %h got %h",
                                     checked, e, updated_position);
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                recv_gap <= $urandom_range(0, 14);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG_LIMIT)
            begin
                $display("timeout waiting on handshake");
                $display("adam_parameter_update_core verification failed");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] rnd32();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed(32'($urandom_range(0, 131072)) - 32'd65536);
            3: return $signed(32'($urandom_range(0, 2097152)) - 32'd1048576);
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic add_word(input logic [6:0] pt, input logic [4:0] dm, input logic ns,
                            input logic signed [31:0] g, input logic signed [31:0] p,
                            input logic signed [31:0] lo, input logic signed [31:0] hi);
        coord_word_t w;
        w = '{pt, dm, ns, g, p, lo, hi};
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic add_random_step(input int n);
        logic [6:0] pt;
        pt = $urandom_range(0, 3) == 0 ? 7'($urandom()) : 7'($urandom_range(0, 3));
        for (int d = 0; d < n; d++)
        begin
            logic signed [31:0] lo, hi;
            lo = $urandom_range(0, 7) == 0 ? rnd32() : -32'sd1 * $urandom_range(0, 1 << 24);
            hi = $urandom_range(0, 7) == 0 ? rnd32() : 32'($urandom_range(0, 1 << 24));
            add_word(pt, 5'($urandom()), d == 0, rnd32(),
                     $urandom_range(0, 1) ? rnd32() : 32'($urandom_range(0, 1 << 20)), lo, hi);
        end
    endtask

    task automatic drain();
        wait (pending_words.size() == 0 && !in_valid);
        wait (expected_pos.size() == 0);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_FIRST_DECAY:  beta1 = val;
            CFG_SECOND_DECAY: beta2 = val;
            default:          lrate = val;
        endcase
    endtask

    initial
    begin
        cfg_we = 0; cfg_index = CFG_FIRST_DECAY; cfg_data = 0;
        foreach (mom1[i]) mom1[i] = 0;
        foreach (mom2[i]) mom2[i] = 0;
        pow1 = ONE_Q31; pow2 = ONE_Q31;
        beta1 = FIRST_DECAY_RST; beta2 = SECOND_DECAY_RST; lrate = STEP_SIZE_RST;
        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;

        // no step started yet: position only clamped; also inverted bounds
        add_word(0, 0, 0, 32'sh0001_0000, 32'sh0005_0000, -32'sh0010_0000, 32'sh0010_0000);
        add_word(1, 1, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000);
        add_word(2, 2, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh0001_0000, 32'sh0000_0000);
        // first step, extremes of every field
        add_word(7'h7F, 5'h1F, 1, 32'sh7FFF_FFFF, 0, 32'sh8000_0000, 32'sh7FFF_FFFF);
        add_word(7'h7F, 5'h1E, 0, 32'sh8000_0000, 0, 32'sh8000_0000, 32'sh7FFF_FFFF);
        add_word(0, 0, 0, -32'sh0001_0000, 32'sh0001_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
        add_word(0, 0, 1, 32'sh0002_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        add_word(0, 0, 0, 32'sh0002_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
        add_word(5, 3, 1, 32'sh0000_0001, 32'sh0000_1000, 32'sh0000_2000, 32'sh0000_1000);
        add_word(5, 3, 0, 0, 0, 0, 0);
        drain();

        write_reg(CFG_FIRST_DECAY, 16'd0);
        write_reg(CFG_SECOND_DECAY, 16'hFFFF);
        write_reg(CFG_STEP_SIZE, 16'hFFFF);
        for (int s = 0; s < 45; s++)
            add_random_step($urandom_range(1, 6));
        // sender holds mid-stream until all results are in, then resumes
        wait (pending_words.size() < 20);
        hold_send = 1;
        wait (expected_pos.size() == 0 && !in_valid);
        repeat (400) @(posedge clk);
        hold_send = 0;
        drain();

        write_reg(CFG_FIRST_DECAY, 16'hFFFF);
        write_reg(CFG_SECOND_DECAY, 16'd0);
        write_reg(CFG_STEP_SIZE, 16'd0);
        for (int s = 0; s < 45; s++)
            add_random_step($urandom_range(1, 6));
        drain();

        write_reg(CFG_FIRST_DECAY, 16'($urandom()));
        write_reg(CFG_SECOND_DECAY, 16'($urandom()));
        write_reg(CFG_STEP_SIZE, 16'($urandom()));
        for (int s = 0; s < 80; s++)
            add_random_step($urandom_range(1, 8));
        drain();

        write_reg(CFG_FIRST_DECAY, FIRST_DECAY_RST);
        write_reg(CFG_SECOND_DECAY, SECOND_DECAY_RST);
        write_reg(CFG_STEP_SIZE, STEP_SIZE_RST);
        for (int s = 0; s < 80; s++)
            add_random_step($urandom_range(1, 8));
        wait (pending_words.size() < 60);
        quiet = 1;
        drain();

        $display("run checked %0d updated coordinates over five phases of register values,",
                 checked);
        $display("with decay and step size at both extremes and random stalls on both sides");
        if (mismatches == 0 && expected_pos.size() == 0)
            $display("adam_parameter_update_core verification clean");
        else
            $display("adam_parameter_update_core verification failed");
        $finish;
    end

endmodule
